/* sv/rssb_pkg.sv */
`default_nettype none

package rssb_pkg;

	localparam int PX_W      = 9;
	localparam int PY_W      = 8;
	localparam int CH_W      = 8;
	localparam int NCH       = 3;
	localparam int PIX_W     = NCH * CH_W;
	localparam int CX_W      = 11;
	localparam int LIM_W     = 9;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// distance datapath
	localparam int DX_W   = 12;
	localparam int SQ_W   = 22;
	localparam int ROOT_W = 19;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int FRAC_W = 11;
	localparam int IDX_W  = ROOT_W - FRAC_W;
	localparam int PROD_W = CH_W + FRAC_W + 1;

	localparam int MAX_FRAMES_DEF   = 256;
	localparam int IMAGE_WIDTH_DEF  = 320;
	localparam int IMAGE_HEIGHT_DEF = 240;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(150);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X    = 2'd0,
		REG_CENTER_Y    = 2'd1,
		REG_FRAME_LIMIT = 2'd2
	} reg_idx_t;

endpackage

`default_nettype wire

/* sv/rssb_if.sv */
`default_nettype none

interface rssb_pix_if;
	logic                       valid;
	logic                       ready;
	logic [rssb_pkg::PX_W-1:0] pixel_x;
	logic [rssb_pkg::PY_W-1:0] pixel_y;
	logic [rssb_pkg::CH_W-1:0] in_red;
	logic [rssb_pkg::CH_W-1:0] in_green;
	logic [rssb_pkg::CH_W-1:0] in_blue;
	logic                       frame_start;

	modport source (
		output valid, output pixel_x, output pixel_y, output in_red, output in_green,
		output in_blue, output frame_start, input ready
	);
	modport sink (
		input valid, input pixel_x, input pixel_y, input in_red, input in_green,
		input in_blue, input frame_start, output ready
	);
endinterface

interface rssb_rgb_if;
	logic                       valid;
	logic                       ready;
	logic [rssb_pkg::CH_W-1:0] out_red;
	logic [rssb_pkg::CH_W-1:0] out_green;
	logic [rssb_pkg::CH_W-1:0] out_blue;

	modport source (output valid, output out_red, output out_green, output out_blue, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue, output ready);
endinterface

`default_nettype wire

/* sv/radial_slit_scan_blend.sv */
// Radial slit-scan blend.
// Input channel "pixel": one pixel per transaction with its coordinates, RGB and a
// frame_start flag that opens a new frame in the history ring. Output channel
// "blend": one blended RGB pixel per input transaction, in input order.
// Configuration: cfg_wen/cfg_index/cfg_data write center_x, center_y and
// frame_limit; write only while no pixel is in flight.
// Throughput: one pixel per cycle while no stall holds the pipeline. The
// datapath runs through the 19-stage square-root pipeline that
// turns the squared distance into a frame age and blend weight; the frame store
// is read at both ages and written through one port in the same cycle.
// Out-of-image pixels are not stored and come out as black.
// Reset: pipeline and output empty, ring empty (the first pixel opens a frame),
// center at 0,0 and frame_limit at 150. Frame store contents are undefined until
// written; no clearing pass is run.
// Stall: the output register plus one skid entry absorb a stalled receiver; the
// input stays ready while the skid entry is free, then the whole pipeline holds.
`default_nettype none

module radial_slit_scan_blend #(
	parameter int MAX_FRAMES   = rssb_pkg::MAX_FRAMES_DEF,
	parameter int IMAGE_WIDTH  = rssb_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = rssb_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [rssb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rssb_pkg::CFG_W-1:0]     cfg_data,
	rssb_pix_if.sink                        pixel,
	rssb_rgb_if.source                      blend
);

	localparam int PX_W   = rssb_pkg::PX_W;
	localparam int PY_W   = rssb_pkg::PY_W;
	localparam int CH_W   = rssb_pkg::CH_W;
	localparam int NCH    = rssb_pkg::NCH;
	localparam int PIX_W  = rssb_pkg::PIX_W;
	localparam int CX_W   = rssb_pkg::CX_W;
	localparam int LIM_W  = rssb_pkg::LIM_W;
	localparam int DX_W   = rssb_pkg::DX_W;
	localparam int SQ_W   = rssb_pkg::SQ_W;
	localparam int ROOT_W = rssb_pkg::ROOT_W;
	localparam int FRAC_W = rssb_pkg::FRAC_W;
	localparam int IDX_W  = rssb_pkg::IDX_W;
	localparam int PROD_W = rssb_pkg::PROD_W;

	localparam int              SLOT_W       = $clog2(MAX_FRAMES);
	localparam longint unsigned FRAME_PIXELS = longint'(IMAGE_WIDTH) * longint'(IMAGE_HEIGHT);
	localparam int              POS_W        = $clog2(FRAME_PIXELS);
	localparam longint unsigned DEPTH        = longint'(MAX_FRAMES) * FRAME_PIXELS;
	localparam int              ADDR_W       = $clog2(DEPTH);
	localparam int              CMP_W        = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [PIX_W-1:0]  pix;
		logic              inb;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] hm1;
	} side_t;

	function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] s,
		input logic [SLOT_W-1:0] a);
		logic [SLOT_W:0] wrap;
		wrap = {1'b0, s} + (SLOT_W+1)'(MAX_FRAMES) - {1'b0, a};
		return (s >= a) ? s - a : SLOT_W'(wrap);
	endfunction

	// configuration
	logic signed [CX_W-1:0] cx_q;
	logic signed [CX_W-1:0] cy_q;
	logic [LIM_W-1:0]       lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			lim_q <= rssb_pkg::LIMIT_RESET;
		end else if (cfg_wen) begin
			unique case (rssb_pkg::reg_idx_t'(cfg_index))
				rssb_pkg::REG_CENTER_X:    cx_q  <= cfg_data[CX_W-1:0];
				rssb_pkg::REG_CENTER_Y:    cy_q  <= cfg_data[CX_W-1:0];
				rssb_pkg::REG_FRAME_LIMIT: lim_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic en;
	logic accept;
	logic sk_valid_q;

	assign en          = ~sk_valid_q;
	assign pixel.ready = en;
	assign accept      = pixel.valid & en;

	logic [SLOT_W-1:0] slot_in;
	logic [SLOT_W-1:0] hm1_in;

	rssb_ring #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (pixel.frame_start),
		.frame_limit (lim_q),
		.slot        (slot_in),
		.hm1         (hm1_in)
	);

	logic signed [DX_W-1:0] dx_in;
	logic signed [DX_W-1:0] dy_in;
	logic                   inb_in;

	assign dx_in = $signed({{(DX_W-PX_W){1'b0}}, pixel.pixel_x})
		- $signed({{(DX_W-CX_W){cx_q[CX_W-1]}}, cx_q});
	assign dy_in = $signed({{(DX_W-PY_W){1'b0}}, pixel.pixel_y})
		- $signed({{(DX_W-CX_W){cy_q[CX_W-1]}}, cy_q});
	assign inb_in = (32'(pixel.pixel_x) < IMAGE_WIDTH) && (32'(pixel.pixel_y) < IMAGE_HEIGHT);

	// pipeline registers
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [DX_W-1:0]   dx_s1, dy_s1;
	logic [PX_W-1:0]          px_s1;
	logic [PY_W-1:0]          py_s1;
	logic [PIX_W-1:0]         pix_s1;
	logic                     inb_s1;
	logic [SLOT_W-1:0]        slot_s1, hm1_s1;

	logic signed [2*DX_W-1:0] sqx_s2, sqy_s2;
	side_t                    side_s2;
	logic [SQ_W-1:0]          sq_s3;
	side_t                    side_s3;

	logic                     vld_rt;
	logic [ROOT_W-1:0]        root_rt;
	side_t                    side_rt;

	logic [SLOT_W-1:0]        sl0_s4, sl1_s4, slot_s4;
	logic [POS_W-1:0]         pos_s4;
	logic [PIX_W-1:0]         pix_s4;
	logic                     inb_s4;
	logic [FRAC_W-1:0]        frac_s4;

	logic [ADDR_W-1:0]        waddr_s5, raddr0_s5, raddr1_s5;
	logic [PIX_W-1:0]         pix_s5;
	logic                     inb_s5;
	logic [FRAC_W-1:0]        frac_s5;

	logic [PIX_W-1:0]         rd0_s6, rd1_s6;
	logic                     inb_s6;
	logic [FRAC_W-1:0]        frac_s6;

	logic [PROD_W-1:0]        pa_s7 [NCH];
	logic [PROD_W-1:0]        pb_s7 [NCH];
	logic                     inb_s7;

	logic [CH_W-1:0]          res_s8 [NCH];

	rssb_isqrt #(
		.SIDE_W ($bits(side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_sq     (sq_s3),
		.in_side   (side_s3),
		.out_valid (vld_rt),
		.out_root  (root_rt),
		.out_side  (side_rt)
	);

	// frame ages and ring slots
	logic [CMP_W-1:0]  i0_c, i1_c, hm_c;
	logic [SLOT_W-1:0] age0, age1;

	always_comb begin
		i0_c = CMP_W'(root_rt[ROOT_W-1:FRAC_W]);
		i1_c = i0_c + CMP_W'(1);
		hm_c = CMP_W'(side_rt.hm1);
		age0 = SLOT_W'((i0_c > hm_c) ? hm_c : i0_c);
		age1 = SLOT_W'((i1_c > hm_c) ? hm_c : i1_c);
	end

	logic [FRAC_W:0] w0;
	assign w0 = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_rt;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_in;
			dy_s1   <= dy_in;
			px_s1   <= pixel.pixel_x;
			py_s1   <= pixel.pixel_y;
			pix_s1  <= {pixel.in_red, pixel.in_green, pixel.in_blue};
			inb_s1  <= inb_in;
			slot_s1 <= slot_in;
			hm1_s1  <= hm1_in;

			sqx_s2       <= dx_s1 * dx_s1;
			sqy_s2       <= dy_s1 * dy_s1;
			side_s2.pos  <= POS_W'(py_s1) * POS_W'(IMAGE_WIDTH) + POS_W'(px_s1);
			side_s2.pix  <= pix_s1;
			side_s2.inb  <= inb_s1;
			side_s2.slot <= slot_s1;
			side_s2.hm1  <= hm1_s1;

			sq_s3   <= sqx_s2[SQ_W-1:0] + sqy_s2[SQ_W-1:0];
			side_s3 <= side_s2;

			sl0_s4  <= ring_back(side_rt.slot, age0);
			sl1_s4  <= ring_back(side_rt.slot, age1);
			slot_s4 <= side_rt.slot;
			pos_s4  <= side_rt.pos;
			pix_s4  <= side_rt.pix;
			inb_s4  <= side_rt.inb;
			frac_s4 <= root_rt[FRAC_W-1:0];

			waddr_s5  <= ADDR_W'(slot_s4) * ADDR_W'(FRAME_PIXELS) + ADDR_W'(pos_s4);
			raddr0_s5 <= ADDR_W'(sl0_s4) * ADDR_W'(FRAME_PIXELS) + ADDR_W'(pos_s4);
			raddr1_s5 <= ADDR_W'(sl1_s4) * ADDR_W'(FRAME_PIXELS) + ADDR_W'(pos_s4);
			pix_s5    <= pix_s4;
			inb_s5    <= inb_s4;
			frac_s5   <= frac_s4;

			inb_s6  <= inb_s5;
			frac_s6 <= frac_s5;

			for (int ch = 0; ch < NCH; ch++) begin
				pa_s7[ch] <= PROD_W'(rd0_s6[PIX_W-CH_W*(ch+1) +: CH_W]) * PROD_W'(w0);
				pb_s7[ch] <= PROD_W'(rd1_s6[PIX_W-CH_W*(ch+1) +: CH_W]) * PROD_W'(frac_s6);
			end
			inb_s7 <= inb_s6;

			for (int ch = 0; ch < NCH; ch++) begin
				res_s8[ch] <= inb_s7 ? CH_W'((pa_s7[ch] + pb_s7[ch]) >> FRAC_W) : '0;
			end
		end
	end

	rssb_frame_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.en     (en),
		.we     (vld_s5 & inb_s5),
		.waddr  (waddr_s5),
		.wdata  (pix_s5),
		.raddr0 (raddr0_s5),
		.raddr1 (raddr1_s5),
		.rdata0 (rd0_s6),
		.rdata1 (rd1_s6)
	);

	// output register and skid entry
	logic            o_valid_q;
	logic [CH_W-1:0] o_q  [NCH];
	logic [CH_W-1:0] sk_q [NCH];
	logic            o_free;
	logic            deliver;

	assign o_free  = ~o_valid_q | blend.ready;
	assign deliver = en & vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (o_free) begin
			if (sk_valid_q) begin
				o_valid_q  <= 1'b1;
				sk_valid_q <= 1'b0;
			end else begin
				o_valid_q <= deliver;
			end
		end else if (deliver) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_free) begin
			if (sk_valid_q) begin
				o_q <= sk_q;
			end else if (deliver) begin
				o_q <= res_s8;
			end
		end else if (deliver) begin
			sk_q <= res_s8;
		end
	end

	assign blend.valid     = o_valid_q;
	assign blend.out_red   = o_q[0];
	assign blend.out_green = o_q[1];
	assign blend.out_blue  = o_q[2];

endmodule

`default_nettype wire

/* sv/rssb_ring.sv */
`default_nettype none

module rssb_ring #(
	parameter int MAX_FRAMES = rssb_pkg::MAX_FRAMES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         frame_start,
	input  logic [rssb_pkg::LIM_W-1:0]  frame_limit,
	output logic [$clog2(MAX_FRAMES)-1:0] slot,
	output logic [$clog2(MAX_FRAMES)-1:0] hm1
);

	localparam int SLOT_W = $clog2(MAX_FRAMES);
	localparam int FH_W   = $clog2(MAX_FRAMES + 1);

	logic [SLOT_W-1:0] newest_q;
	logic [FH_W-1:0]   held_q;
	logic [FH_W-1:0]   lim_eff;
	logic [FH_W-1:0]   held_nxt;
	logic [FH_W-1:0]   held_rd;
	logic [FH_W:0]     held_inc;
	logic              adv;

	always_comb begin
		if (frame_limit == '0) begin
			lim_eff = FH_W'(1);
		end else if (32'(frame_limit) > MAX_FRAMES) begin
			lim_eff = FH_W'(MAX_FRAMES);
		end else begin
			lim_eff = FH_W'(frame_limit);
		end
	end

	assign adv      = frame_start | (held_q == '0);
	assign held_inc = {1'b0, held_q} + (FH_W+1)'(1);

	always_comb begin
		if (!adv) begin
			slot     = newest_q;
			held_nxt = held_q;
		end else begin
			slot     = (32'(newest_q) == MAX_FRAMES - 1) ? '0 : newest_q + SLOT_W'(1);
			held_nxt = (held_inc > {1'b0, lim_eff}) ? lim_eff : held_inc[FH_W-1:0];
		end
		held_rd = (held_nxt > lim_eff) ? lim_eff : held_nxt;
		hm1     = SLOT_W'(held_rd - FH_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			held_q   <= '0;
		end else if (accept) begin
			newest_q <= slot;
			held_q   <= held_nxt;
		end
	end

endmodule

`default_nettype wire

/* sv/rssb_isqrt.sv */
`default_nettype none

module rssb_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [rssb_pkg::SQ_W-1:0]   in_sq,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [rssb_pkg::ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0]            out_side
);

	localparam int ROOT_W = rssb_pkg::ROOT_W;
	localparam int RAD_W  = rssb_pkg::RAD_W;
	localparam int SQ_W   = rssb_pkg::SQ_W;
	localparam int NST    = ROOT_W;
	localparam int RM_W   = ROOT_W + 1;

	logic              vld_s  [NST];
	logic [RM_W-1:0]   rem_s  [NST];
	logic [ROOT_W-1:0] root_s [NST];
	logic [RAD_W-1:0]  rad_s  [NST];
	logic [SIDE_W-1:0] side_s [NST];

	logic [RM_W-1:0]   p_rem  [NST];
	logic [ROOT_W-1:0] p_root [NST];
	logic [RAD_W-1:0]  p_rad  [NST];
	logic [RM_W-1:0]   n_rem  [NST];
	logic [ROOT_W-1:0] n_root [NST];
	logic [RAD_W-1:0]  n_rad  [NST];

	// one result bit per stage: restoring square root on digit pairs
	always_comb begin
		logic [RM_W+1:0] cur;
		logic [RM_W+1:0] trial;
		logic            ge;
		p_rem[0]  = '0;
		p_root[0] = '0;
		p_rad[0]  = {in_sq, {(RAD_W-SQ_W){1'b0}}};
		for (int k = 1; k < NST; k++) begin
			p_rem[k]  = rem_s[k-1];
			p_root[k] = root_s[k-1];
			p_rad[k]  = rad_s[k-1];
		end
		for (int k = 0; k < NST; k++) begin
			cur       = {p_rem[k], p_rad[k][RAD_W-1 -: 2]};
			trial     = {{(RM_W-ROOT_W){1'b0}}, p_root[k], 2'b01};
			ge        = (cur >= trial);
			n_rem[k]  = ge ? RM_W'(cur - trial) : RM_W'(cur);
			n_root[k] = {p_root[k][ROOT_W-2:0], ge};
			n_rad[k]  = p_rad[k] << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 0; k < NST; k++) begin
				rem_s[k]  <= n_rem[k];
				root_s[k] <= n_root[k];
				rad_s[k]  <= n_rad[k];
			end
			for (int k = 1; k < NST; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_root  = root_s[NST-1];
	assign out_side  = side_s[NST-1];

endmodule

`default_nettype wire

/* sv/rssb_frame_mem.sv */
`default_nettype none

module rssb_frame_mem #(
	parameter longint unsigned DEPTH  = 64'd19660800,
	parameter int              ADDR_W = 25
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [rssb_pkg::PIX_W-1:0] wdata,
	input  logic [ADDR_W-1:0]           raddr0,
	input  logic [ADDR_W-1:0]           raddr1,
	output logic [rssb_pkg::PIX_W-1:0] rdata0,
	output logic [rssb_pkg::PIX_W-1:0] rdata1
);

	logic [rssb_pkg::PIX_W-1:0] mem [DEPTH];

	// same-cycle write is visible to the reads
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata0 <= (we && raddr0 == waddr) ? wdata : mem[raddr0];
			rdata1 <= (we && raddr1 == waddr) ? wdata : mem[raddr1];
		end
	end

endmodule

`default_nettype wire

/* tb/radial_slit_scan_blend_tb.sv */
`timescale 1ns / 100ps

module radial_slit_scan_blend_tb;
	import rssb_pkg::*;

	localparam int NPOS         = 4;
	localparam int FRAME_PIXELS = IMAGE_WIDTH_DEF * IMAGE_HEIGHT_DEF;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [PX_W-1:0] x;
		logic [PY_W-1:0] y;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            fs;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rssb_pix_if pix ();
	rssb_rgb_if rgb ();

	radial_slit_scan_blend uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pix),
		.blend(rgb)
	);

	always #1 clk = ~clk;

	pixel_t pixel_queue[$];
	rgb_t blend_expected[$];
	pixel_t drive_pix;

	// shadow of the block's ring and registers
	logic [PIX_W-1:0] frame_history[int];
	int model_newest;
	int model_held;
	logic signed [CX_W-1:0] model_cx;
	logic signed [CX_W-1:0] model_cy;
	logic [LIM_W-1:0] model_limit;

	// positions written by every frame while more than one frame is read
	int spot_x[NPOS];
	int spot_y[NPOS];

	int send_idle_pct;
	int recv_idle_pct;
	int queued;
	int pixels_sent;
	int results_checked;
	int ring_advances;
	int reg_writes;
	int errors;
	int stall_cycles;

	function automatic logic [19:0] square_root(input logic [39:0] v);
		logic [19:0] root;
		logic [39:0] trial;
		root = '0;
		for (int bit_i = 19; bit_i >= 0; bit_i--) begin
			trial = 40'(root | (20'd1 << bit_i));
			if (trial * trial <= v)
				root = trial[19:0];
		end
		return root;
	endfunction

	function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] near_c,
			input logic [CH_W-1:0] far_c, input int frac);
		return CH_W'((int'(near_c) * (2048 - frac) + int'(far_c) * frac) >> 11);
	endfunction

	function automatic rgb_t blend_predict(input pixel_t p);
		rgb_t res;
		int lim, held, pos, dx, dy, age0, age1, frac, slot0, slot1;
		logic [39:0] sq;
		logic [19:0] radius;
		logic [PIX_W-1:0] c0, c1;
		if (model_limit == 0)
			lim = 1;
		else if (model_limit > MAX_FRAMES_DEF)
			lim = MAX_FRAMES_DEF;
		else
			lim = int'(model_limit);
		if (p.fs || model_held == 0) begin
			model_newest = (model_newest + 1) % MAX_FRAMES_DEF;
			model_held = (model_held + 1 > lim) ? lim : model_held + 1;
			ring_advances++;
		end
		res = '0;
		if (p.x >= IMAGE_WIDTH_DEF || p.y >= IMAGE_HEIGHT_DEF)
			return res;
		pos = int'(p.y) * IMAGE_WIDTH_DEF + int'(p.x);
		frame_history[model_newest * FRAME_PIXELS + pos] = {p.r, p.g, p.b};
		held = (model_held < lim) ? model_held : lim;
		if (held == 0)
			held = 1;
		dx = int'(p.x) - int'(model_cx);
		dy = int'(p.y) - int'(model_cy);
		sq = 40'(dx * dx + dy * dy);
		sq = sq << 16;
		radius = square_root(sq);
		age0 = int'(radius >> FRAC_W);
		frac = int'(radius[FRAC_W-1:0]);
		age1 = age0 + 1;
		if (age0 > held - 1)
			age0 = held - 1;
		if (age1 > held - 1)
			age1 = held - 1;
		slot0 = (model_newest + MAX_FRAMES_DEF - age0) % MAX_FRAMES_DEF;
		slot1 = (model_newest + MAX_FRAMES_DEF - age1) % MAX_FRAMES_DEF;
		c0 = frame_history.exists(slot0 * FRAME_PIXELS + pos) ?
			frame_history[slot0 * FRAME_PIXELS + pos] : '0;
		c1 = frame_history.exists(slot1 * FRAME_PIXELS + pos) ?
			frame_history[slot1 * FRAME_PIXELS + pos] : '0;
		res.r = mix(c0[23:16], c1[23:16], frac);
		res.g = mix(c0[15:8], c1[15:8], frac);
		res.b = mix(c0[7:0], c1[7:0], frac);
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.pixel_x <= '0;
			pix.pixel_y <= '0;
			pix.in_red <= '0;
			pix.in_green <= '0;
			pix.in_blue <= '0;
			pix.frame_start <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				blend_expected.push_back(blend_predict(drive_pix));
				pixels_sent++;
			end
			if (!pix.valid || pix.ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_pix = pixel_queue.pop_front();
					pix.valid <= 1'b1;
					pix.pixel_x <= drive_pix.x;
					pix.pixel_y <= drive_pix.y;
					pix.in_red <= drive_pix.r;
					pix.in_green <= drive_pix.g;
					pix.in_blue <= drive_pix.b;
					pix.frame_start <= drive_pix.fs;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			rgb.ready <= 1'b0;
		end else begin
			if (rgb.valid && rgb.ready) begin
				if (blend_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, actual %02h %02h %02h", $time,
						rgb.out_red, rgb.out_green, rgb.out_blue);
				end else begin
					want = blend_expected.pop_front();
					report_field("out_red", want.r, rgb.out_red);
					report_field("out_green", want.g, rgb.out_green);
					report_field("out_blue", want.b, rgb.out_blue);
					results_checked++;
				end
			end
			rgb.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic pixel_t make_pixel(input int x, input int y, input bit fs,
			input logic [PIX_W-1:0] color);
		pixel_t p;
		p.x = PX_W'(x);
		p.y = PY_W'(y);
		{p.r, p.g, p.b} = color;
		p.fs = fs;
		return p;
	endfunction

	function automatic pixel_t paint(input int x, input int y, input bit fs);
		return make_pixel(x, y, fs, PIX_W'($urandom));
	endfunction

	function automatic pixel_t offscreen(input bit fs);
		pixel_t p;
		p = paint($urandom_range(511), $urandom_range(255), fs);
		if ($urandom_range(1))
			p.x = PX_W'($urandom_range(511, IMAGE_WIDTH_DEF));
		else
			p.y = PY_W'($urandom_range(255, IMAGE_HEIGHT_DEF));
		return p;
	endfunction

	task automatic send(input pixel_t p);
		pixel_queue.push_back(p);
		queued++;
	endtask

	// a frame that writes every spot, in random order, with repeats and noise
	task automatic queue_full_frame();
		int order[NPOS];
		int j, t, k;
		bit opening;
		for (int i = 0; i < NPOS; i++)
			order[i] = i;
		for (int i = NPOS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		opening = 1'b1;
		if ($urandom_range(7) == 0) begin
			send(offscreen(1'b1));
			opening = 1'b0;
		end
		for (int i = 0; i < NPOS; i++) begin
			send(paint(spot_x[order[i]], spot_y[order[i]], opening));
			opening = 1'b0;
			k = $urandom_range(NPOS - 1);
			case ($urandom_range(7))
				0: send(paint(spot_x[k], spot_y[k], 1'b0));
				1: send(offscreen(1'b0));
				default: ;
			endcase
		end
	endtask

	// only valid while a single frame is read: any position at all
	task automatic queue_free_frame();
		send(paint($urandom_range(511), $urandom_range(255), 1'b1));
		if ($urandom_range(3) == 0)
			send(paint($urandom_range(511), $urandom_range(255), 1'b0));
	endtask

	task automatic drain();
		while (pixel_queue.size() != 0 || pix.valid || blend_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic apply_config(input int cx, input int cy, input int limit);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_data <= CFG_W'(cx);
		model_cx = CX_W'(cx);
		@(posedge clk);
		cfg_index <= REG_CENTER_Y;
		cfg_data <= CFG_W'(cy);
		model_cy = CX_W'(cy);
		@(posedge clk);
		cfg_index <= REG_FRAME_LIMIT;
		cfg_data <= CFG_W'(limit);
		model_limit = LIM_W'(limit);
		@(posedge clk);
		cfg_wen <= 1'b0;
		reg_writes += 3;
	endtask

	// ends on a complete frame so that later phases may read back through it
	task automatic run_phase(input int n, input bit free_frames);
		int start;
		start = queued;
		while (queued - start < n) begin
			if (free_frames)
				queue_free_frame();
			else
				queue_full_frame();
		end
		if (free_frames)
			queue_full_frame();
		drain();
	endtask

	function automatic int any_center();
		return int'($urandom_range(2047)) - 1024;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		pix.in_red = '0;
		pix.in_green = '0;
		pix.in_blue = '0;
		pix.frame_start = 1'b0;
		rgb.ready = 1'b0;
		model_newest = 0;
		model_held = 0;
		model_cx = '0;
		model_cy = '0;
		model_limit = LIMIT_RESET;
		queued = 0;
		pixels_sent = 0;
		results_checked = 0;
		ring_advances = 0;
		reg_writes = 0;
		errors = 0;
		stall_cycles = 0;
		send_idle_pct = 32;
		recv_idle_pct = 49;
		spot_x[0] = 0;
		spot_y[0] = 0;
		spot_x[1] = IMAGE_WIDTH_DEF - 1;
		spot_y[1] = IMAGE_HEIGHT_DEF - 1;
		for (int i = 2; i < NPOS; i++) begin
			spot_x[i] = $urandom_range(IMAGE_WIDTH_DEF - 1);
			spot_y[i] = $urandom_range(IMAGE_HEIGHT_DEF - 1);
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers; first pixel opens a frame without frame_start
		send(make_pixel(0, 0, 1'b0, 24'hff0080));
		send(make_pixel(319, 239, 1'b0, 24'h00ff7f));
		send(paint(spot_x[2], spot_y[2], 1'b0));
		send(paint(spot_x[3], spot_y[3], 1'b0));
		send(make_pixel(320, 0, 1'b0, 24'h123456));
		send(make_pixel(0, 240, 1'b0, 24'hffffff));
		send(make_pixel(511, 255, 1'b0, 24'hffffff));
		// off-image pixel still advances the ring
		send(make_pixel(511, 255, 1'b1, 24'hffffff));
		send(make_pixel(0, 0, 1'b0, 24'hffffff));
		send(make_pixel(319, 239, 1'b0, 24'h000000));
		send(paint(spot_x[2], spot_y[2], 1'b0));
		send(paint(spot_x[3], spot_y[3], 1'b0));
		send(make_pixel(0, 0, 1'b1, 24'h000000));
		send(make_pixel(319, 239, 1'b0, 24'hffffff));
		send(paint(spot_x[2], spot_y[2], 1'b0));
		send(paint(spot_x[3], spot_y[3], 1'b0));
		send(make_pixel(0, 0, 1'b0, 24'hffffff));
		run_phase(40, 1'b0);

		// limit above the ring size, center at the far corner
		apply_config(-1024, -1024, 511);
		run_phase(170, 1'b0);
		apply_config(1023, 1023, MAX_FRAMES_DEF);
		run_phase(60, 1'b0);

		send_idle_pct = 49;
		recv_idle_pct = 32;
		apply_config(any_center(), any_center(), 1);
		run_phase(200, 1'b1);
		// zero limit behaves as one
		apply_config(0, 0, 0);
		run_phase(60, 1'b1);
		apply_config(any_center(), any_center(), 3);
		run_phase(80, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_config($urandom_range(IMAGE_WIDTH_DEF - 1), $urandom_range(IMAGE_HEIGHT_DEF - 1),
			MAX_FRAMES_DEF);
		run_phase(120, 1'b0);
		// lowered below the frames held
		apply_config($urandom_range(IMAGE_WIDTH_DEF - 1), $urandom_range(IMAGE_HEIGHT_DEF - 1),
			$urandom_range(10, 2));
		run_phase(80, 1'b0);
		apply_config(any_center(), any_center(), 1);
		run_phase(40, 1'b1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (blend_expected.size() != 0) begin
			errors += blend_expected.size();
			$display("%0t: %0d expected transactions never arrived", $time,
				blend_expected.size());
		end
		$display("Sent %0d pixels over %0d frame advances and %0d register writes;",
			pixels_sent, ring_advances, reg_writes);
		$display("checked %0d blended pixels, %0d errors.", results_checked, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
